// ===== hw/rtl/interpolating_multitone_upconverter_macros.svh =====
// Assertion macros shared by the RTL. Clock clk and reset arst_n are implied.
`ifndef INTERPOLATING_MULTITONE_UPCONVERTER_MACROS_SVH
`define INTERPOLATING_MULTITONE_UPCONVERTER_MACROS_SVH

// Flag any cycle in which cond holds
`define IMU_ASSERT_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("imu assertion failed: forbidden condition");

// Flag a cycle with trig that is not followed by resp in the next cycle
`define IMU_ASSERT_NEXT(lbl, trig, resp) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (resp)) \
		else $error("imu assertion failed: missing response");

`endif

// ===== hw/rtl/imu_pkg.sv =====
`default_nettype none
package imu_pkg;

	localparam int NUM_TONES_DEF  = 2;
	localparam int MAX_RATIO_DEF  = 64;
	localparam int SINE_BITS_DEF  = 10;
	localparam int MAX_TONES      = 2;
	localparam int DATA_W         = 16;
	localparam int RATIO_W        = 7;
	localparam int TONES_W        = 2;
	localparam int PHASE_W        = 32;
	localparam int INC_W          = 33;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 32;
	localparam int JOB_DEPTH      = 2;
	localparam int OUT_DEPTH      = 4;
	localparam int OUT_LVL_W      = $clog2(OUT_DEPTH + 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_UPSAMPLE_RATIO = 3'd0,
		REG_TONE_COUNT     = 3'd1,
		REG_PHASE_STEP_A   = 3'd2,
		REG_PHASE_STEP_B   = 3'd3,
		REG_PHASE_OFFSET_A = 3'd4,
		REG_PHASE_OFFSET_B = 3'd5
	} cfg_reg_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_DIV,
		F_SEND
	} front_state_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] sample_i;
		logic signed [DATA_W-1:0] sample_q;
	} in_item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] out_i;
		logic signed [DATA_W-1:0] out_q;
		logic                     last;
	} out_item_t;

	// One interpolation interval handed from front to back
	typedef struct packed {
		logic signed [DATA_W-1:0] prev_i;
		logic signed [DATA_W-1:0] prev_q;
		logic signed [INC_W-1:0]  inc_i;
		logic signed [INC_W-1:0]  inc_q;
	} job_t;

	typedef struct packed {
		logic have_prev;
		logic dividing;
	} front_stat_t;

	// Quarter-wave sine entry k, Q15, for a table of 2^bits entries per turn.
	// Used at elaboration only.
	function automatic logic [DATA_W-1:0] quarter_sin(input int k, input int bits);
		longint x;
		longint x2;
		longint t;
		longint s;
		longint v;
		x  = (longint'(k) * 64'sd1686629713) >>> (bits - 2);
		x2 = (x * x) >>> 30;
		s  = x;
		t  = x;
		t  = ((t * x2) >>> 30) / 6;
		s  = s - t;
		t  = ((t * x2) >>> 30) / 20;
		s  = s + t;
		t  = ((t * x2) >>> 30) / 42;
		s  = s - t;
		t  = ((t * x2) >>> 30) / 72;
		s  = s + t;
		t  = ((t * x2) >>> 30) / 110;
		s  = s - t;
		t  = ((t * x2) >>> 30) / 156;
		s  = s + t;
		t  = ((t * x2) >>> 30) / 210;
		s  = s - t;
		if (s < 0) begin
			s = 0;
		end
		v = (s + 16384) >>> 15;
		if (v > 32767) begin
			v = 32767;
		end
		return v[DATA_W-1:0];
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/imu_fifo.sv =====
`default_nettype none
module imu_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         wr,
	input  wire logic [WIDTH-1:0]             wdata,
	input  wire logic                         rd,
	output logic      [WIDTH-1:0]             rdata,
	output logic                              full,
	output logic                              empty,
	output logic      [$clog2(DEPTH+1)-1:0]   level
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wptr_q;
	logic [PW-1:0]    rptr_q;
	logic [LW-1:0]    cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full  = (cnt_q == LW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign level = cnt_q;
	assign rdata = mem_q[rptr_q];
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;

	// Store entries
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/imu_front.sv =====
`default_nettype none
module imu_front
	import imu_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire in_item_t           sample,
	output logic                    full,
	input  wire logic [RATIO_W-1:0] ratio,
	output job_t                    job,
	output logic                    job_wr,
	input  wire logic               job_full,
	output front_stat_t             stat
);
	front_state_t state_q, state_d;

	logic signed [DATA_W-1:0] prev_i_q, prev_q_q;
	logic signed [DATA_W-1:0] jprev_i_q, jprev_q_q;
	logic                     have_prev_q;
	logic [PHASE_W-1:0]       dvd_i_q, dvd_q_q;
	logic [RATIO_W-1:0]       rem_i_q, rem_q_q;
	logic                     neg_i_q, neg_q_q;
	logic [4:0]               cnt_q;

	logic                     accept;
	logic signed [DATA_W:0]   diff_i, diff_q;
	logic [DATA_W:0]          mag_i, mag_q;
	logic [RATIO_W:0]         sh_i, sh_q;
	logic                     ge_i, ge_q;
	logic [RATIO_W:0]         nrem_i, nrem_q;

	assign accept = push && !full;
	assign diff_i = {sample.sample_i[DATA_W-1], sample.sample_i} - {prev_i_q[DATA_W-1], prev_i_q};
	assign diff_q = {sample.sample_q[DATA_W-1], sample.sample_q} - {prev_q_q[DATA_W-1], prev_q_q};
	assign mag_i  = diff_i[DATA_W] ? (DATA_W+1)'(-diff_i) : diff_i;
	assign mag_q  = diff_q[DATA_W] ? (DATA_W+1)'(-diff_q) : diff_q;

	// One restoring division step per cycle on both components
	assign sh_i   = {rem_i_q, dvd_i_q[PHASE_W-1]};
	assign sh_q   = {rem_q_q, dvd_q_q[PHASE_W-1]};
	assign ge_i   = sh_i >= {1'b0, ratio};
	assign ge_q   = sh_q >= {1'b0, ratio};
	assign nrem_i = ge_i ? sh_i - {1'b0, ratio} : sh_i;
	assign nrem_q = ge_q ? sh_q - {1'b0, ratio} : sh_q;

	// Apply the sign to the quotient
	assign job.prev_i = jprev_i_q;
	assign job.prev_q = jprev_q_q;
	assign job.inc_i  = neg_i_q ? -$signed({1'b0, dvd_i_q}) : $signed({1'b0, dvd_i_q});
	assign job.inc_q  = neg_q_q ? -$signed({1'b0, dvd_q_q}) : $signed({1'b0, dvd_q_q});

	assign stat.have_prev = have_prev_q;
	assign stat.dividing  = (state_q == F_DIV);

	// Next state and handshake
	always_comb begin
		state_d = state_q;
		full    = 1'b1;
		job_wr  = 1'b0;
		unique case (state_q)
			F_IDLE: begin
				full = 1'b0;
				if (accept && have_prev_q) begin
					state_d = F_DIV;
				end
			end
			F_DIV: begin
				if (cnt_q == 5'd31) begin
					state_d = F_SEND;
				end
			end
			F_SEND: begin
				job_wr = !job_full;
				if (!job_full) begin
					state_d = F_IDLE;
				end
			end
			default: state_d = F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= F_IDLE;
			have_prev_q <= 1'b0;
			prev_i_q    <= '0;
			prev_q_q    <= '0;
			cnt_q       <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				prev_i_q    <= sample.sample_i;
				prev_q_q    <= sample.sample_q;
				have_prev_q <= 1'b1;
				cnt_q       <= '0;
			end else if (state_q == F_DIV) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// Load the dividend, then shift quotient bits in
	always_ff @(posedge clk) begin
		if (accept) begin
			jprev_i_q <= prev_i_q;
			jprev_q_q <= prev_q_q;
			dvd_i_q   <= {mag_i[DATA_W-1:0], {DATA_W{1'b0}}};
			dvd_q_q   <= {mag_q[DATA_W-1:0], {DATA_W{1'b0}}};
			neg_i_q   <= diff_i[DATA_W];
			neg_q_q   <= diff_q[DATA_W];
			rem_i_q   <= '0;
			rem_q_q   <= '0;
		end else if (state_q == F_DIV) begin
			dvd_i_q <= {dvd_i_q[PHASE_W-2:0], ge_i};
			dvd_q_q <= {dvd_q_q[PHASE_W-2:0], ge_q};
			rem_i_q <= nrem_i[RATIO_W-1:0];
			rem_q_q <= nrem_q[RATIO_W-1:0];
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/imu_back.sv =====
`default_nettype none
module imu_back
	import imu_pkg::*;
#(
	parameter int NUM_TONES       = NUM_TONES_DEF,
	parameter int SINE_TABLE_BITS = SINE_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire job_t                            job,
	input  wire logic                            job_valid,
	output logic                                 job_pop,
	input  wire logic [RATIO_W-1:0]              ratio,
	input  wire logic [TONES_W-1:0]              tones,
	input  wire logic [MAX_TONES-1:0][PHASE_W-1:0] phase_step,
	input  wire logic [MAX_TONES-1:0][PHASE_W-1:0] phase_offset,
	input  wire logic [OUT_LVL_W-1:0]            out_level,
	output logic                                 out_wr,
	output out_item_t                            out_item
);
	localparam int TB      = SINE_TABLE_BITS;
	localparam int QUARTER = 1 << (TB - 2);
	localparam int QA      = TB - 1;
	localparam int PW      = INC_W + DATA_W;
	localparam int SW      = PW + 2;

	logic signed [DATA_W-1:0] qtab [QUARTER+1];

	// Quarter-wave sine table
	for (genvar m = 0; m <= QUARTER; m++) begin : g_tab
		assign qtab[m] = $signed(quarter_sin(m, TB));
	end

	function automatic logic signed [DATA_W-1:0] tab_read(input logic [TB-1:0] idx);
		logic [QA-1:0]            addr;
		logic signed [DATA_W-1:0] v;
		addr = idx[TB-2] ? QA'(QUARTER) - QA'(idx[TB-3:0]) : QA'(idx[TB-3:0]);
		v    = qtab[addr];
		return idx[TB-1] ? -v : v;
	endfunction

	logic                    active_q;
	logic [RATIO_W-1:0]      cnt_q;
	logic signed [INC_W-1:0] acc_i_q, acc_q_q, inc_i_q, inc_q_q;
	logic [PHASE_W-1:0]      phase_q [NUM_TONES];
	logic                    issue, last;
	logic [OUT_LVL_W+1:0]    used;

	logic                     v_s1, last_s1;
	logic signed [INC_W-1:0]  acc_i_s1, acc_q_s1;
	logic signed [DATA_W-1:0] sin_s1 [NUM_TONES];
	logic signed [DATA_W-1:0] cos_s1 [NUM_TONES];
	logic signed [DATA_W-1:0] sin_d  [NUM_TONES];
	logic signed [DATA_W-1:0] cos_d  [NUM_TONES];

	logic                     v_s2, last_s2;
	logic signed [PW-1:0]     ic_s2 [NUM_TONES];
	logic signed [PW-1:0]     qs_s2 [NUM_TONES];
	logic signed [PW-1:0]     is_s2 [NUM_TONES];
	logic signed [PW-1:0]     qc_s2 [NUM_TONES];

	logic signed [SW-1:0]     sum_i, sum_q, rnd_i, rnd_q;
	logic signed [SW-32:0]    sh_i, sh_q;

	// Issue only with room in the result queue for everything in flight
	assign used    = (OUT_LVL_W+2)'(out_level) + (OUT_LVL_W+2)'(v_s1) + (OUT_LVL_W+2)'(v_s2);
	assign issue   = active_q && (used < (OUT_LVL_W+2)'(OUT_DEPTH));
	assign last    = (cnt_q == ratio - 1'b1);
	assign job_pop = !active_q && job_valid;

	// Table lookup per tone, zeroed when the tone is off
	always_comb begin
		for (int t = 0; t < NUM_TONES; t++) begin
			logic [PHASE_W-1:0] p;
			logic [TB-1:0]      idx;
			p   = phase_q[t] + phase_offset[t];
			idx = p[PHASE_W-1 -: TB];
			if (TONES_W'(t) < tones) begin
				sin_d[t] = tab_read(idx);
				cos_d[t] = tab_read(idx + TB'(QUARTER));
			end else begin
				sin_d[t] = '0;
				cos_d[t] = '0;
			end
		end
	end

	// Interval sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			cnt_q    <= '0;
			for (int t = 0; t < NUM_TONES; t++) begin
				phase_q[t] <= '0;
			end
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (job_pop) begin
				active_q <= 1'b1;
				cnt_q    <= '0;
			end else if (issue) begin
				cnt_q <= cnt_q + 1'b1;
				if (last) begin
					active_q <= 1'b0;
				end
				for (int t = 0; t < NUM_TONES; t++) begin
					phase_q[t] <= phase_q[t] + phase_step[t];
				end
			end
			v_s1 <= issue;
			v_s2 <= v_s1;
		end
	end

	// Interpolation accumulators and pipeline payload
	always_ff @(posedge clk) begin
		if (job_pop) begin
			acc_i_q <= {job.prev_i[DATA_W-1], job.prev_i, {DATA_W{1'b0}}};
			acc_q_q <= {job.prev_q[DATA_W-1], job.prev_q, {DATA_W{1'b0}}};
			inc_i_q <= job.inc_i;
			inc_q_q <= job.inc_q;
		end else if (issue) begin
			acc_i_q <= acc_i_q + inc_i_q;
			acc_q_q <= acc_q_q + inc_q_q;
		end
		acc_i_s1 <= acc_i_q;
		acc_q_s1 <= acc_q_q;
		last_s1  <= last;
		for (int t = 0; t < NUM_TONES; t++) begin
			sin_s1[t] <= sin_d[t];
			cos_s1[t] <= cos_d[t];
			ic_s2[t]  <= PW'(acc_i_s1 * cos_s1[t]);
			qs_s2[t]  <= PW'(acc_q_s1 * sin_s1[t]);
			is_s2[t]  <= PW'(acc_i_s1 * sin_s1[t]);
			qc_s2[t]  <= PW'(acc_q_s1 * cos_s1[t]);
		end
		last_s2 <= last_s1;
	end

	// Sum tones, round, saturate
	always_comb begin
		sum_i = '0;
		sum_q = '0;
		for (int t = 0; t < NUM_TONES; t++) begin
			sum_i = sum_i + SW'(ic_s2[t]) - SW'(qs_s2[t]);
			sum_q = sum_q + SW'(is_s2[t]) + SW'(qc_s2[t]);
		end
		rnd_i = sum_i + (SW'(1) <<< 30);
		rnd_q = sum_q + (SW'(1) <<< 30);
		sh_i  = rnd_i[SW-1:31];
		sh_q  = rnd_q[SW-1:31];
		if (sh_i > (SW-31)'(32767)) begin
			out_item.out_i = 16'sh7FFF;
		end else if (sh_i < -(SW-31)'(32768)) begin
			out_item.out_i = 16'sh8000;
		end else begin
			out_item.out_i = sh_i[DATA_W-1:0];
		end
		if (sh_q > (SW-31)'(32767)) begin
			out_item.out_q = 16'sh7FFF;
		end else if (sh_q < -(SW-31)'(32768)) begin
			out_item.out_q = 16'sh8000;
		end else begin
			out_item.out_q = sh_q[DATA_W-1:0];
		end
		out_item.last = last_s2;
		out_wr        = v_s2;
	end
endmodule
`default_nettype wire

// ===== hw/rtl/interpolating_multitone_upconverter.sv =====
// Channel   | Ports                        | Transaction
// ----------+------------------------------+-------------------------------------
// input     | push, full, sample           | push && !full, one baseband sample
// result    | empty, pop, result           | pop && !empty, one RF sample
// config    | cfg_we, cfg_index, cfg_data  | cfg_we, register write, no wait
//
// The front divides the step by the ratio one quotient bit per cycle, overlapped
// with the back, which emits one RF sample per cycle while the result queue has room.
// Issued samples pass through the s1 and s2 registers into the result queue.
// The first item after reset only loads the previous sample and gives no result.
// Reset clears phases, previous sample and registers to their defaults.
// A full result queue stalls the back; a full job queue stalls the front.
`default_nettype none
`include "interpolating_multitone_upconverter_macros.svh"
module interpolating_multitone_upconverter
	import imu_pkg::*;
#(
	parameter int NUM_TONES       = NUM_TONES_DEF,
	parameter int MAX_RATIO       = MAX_RATIO_DEF,
	parameter int SINE_TABLE_BITS = SINE_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	output logic                       full,
	input  wire in_item_t              sample,
	output logic                       empty,
	input  wire logic                  pop,
	output out_item_t                  result,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);
	logic [RATIO_W-1:0]              ratio_q, ratio_eff;
	logic [TONES_W-1:0]              tones_q, tones_eff;
	logic [MAX_TONES-1:0][PHASE_W-1:0] step_q, offset_q;

	job_t            job_in, job_out;
	logic            job_wr, job_full, job_empty, job_pop;
	front_stat_t     fstat;
	out_item_t       out_item;
	logic            out_wr, out_full;
	logic [OUT_LVL_W-1:0] out_level;
	logic [$clog2(JOB_DEPTH+1)-1:0] job_level;

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_q  <= RATIO_W'(1);
			tones_q  <= TONES_W'(1);
			step_q   <= '0;
			offset_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_UPSAMPLE_RATIO: ratio_q     <= cfg_data[RATIO_W-1:0];
				REG_TONE_COUNT:     tones_q     <= cfg_data[TONES_W-1:0];
				REG_PHASE_STEP_A:   step_q[0]   <= cfg_data;
				REG_PHASE_STEP_B:   step_q[1]   <= cfg_data;
				REG_PHASE_OFFSET_A: offset_q[0] <= cfg_data;
				REG_PHASE_OFFSET_B: offset_q[1] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Clamp ratio and tone count
	always_comb begin
		priority if (ratio_q == '0) begin
			ratio_eff = RATIO_W'(1);
		end else if (ratio_q > RATIO_W'(MAX_RATIO)) begin
			ratio_eff = RATIO_W'(MAX_RATIO);
		end else begin
			ratio_eff = ratio_q;
		end
		tones_eff = (tones_q > TONES_W'(NUM_TONES)) ? TONES_W'(NUM_TONES) : tones_q;
	end

	imu_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.sample   (sample),
		.full     (full),
		.ratio    (ratio_eff),
		.job      (job_in),
		.job_wr   (job_wr),
		.job_full (job_full),
		.stat     (fstat)
	);

	imu_fifo #(
		.WIDTH ($bits(job_t)),
		.DEPTH (JOB_DEPTH)
	) u_job_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (job_wr),
		.wdata  (job_in),
		.rd     (job_pop),
		.rdata  (job_out),
		.full   (job_full),
		.empty  (job_empty),
		.level  (job_level)
	);

	imu_back #(
		.NUM_TONES       (NUM_TONES),
		.SINE_TABLE_BITS (SINE_TABLE_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.job          (job_out),
		.job_valid    (!job_empty),
		.job_pop      (job_pop),
		.ratio        (ratio_eff),
		.tones        (tones_eff),
		.phase_step   (step_q),
		.phase_offset (offset_q),
		.out_level    (out_level),
		.out_wr       (out_wr),
		.out_item     (out_item)
	);

	imu_fifo #(
		.WIDTH ($bits(out_item_t)),
		.DEPTH (OUT_DEPTH)
	) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (out_wr),
		.wdata  (out_item),
		.rd     (pop),
		.rdata  (result),
		.full   (out_full),
		.empty  (empty),
		.level  (out_level)
	);

	`IMU_ASSERT_NEVER(a_out_overflow, out_wr && out_full)
	`IMU_ASSERT_NEVER(a_job_overflow, job_wr && (job_full || job_level > 2'(JOB_DEPTH)))
	`IMU_ASSERT_NEXT(a_busy_after_item, push && !full && fstat.have_prev, full && fstat.dividing)
endmodule
`default_nettype wire

// ===== bench/interpolating_multitone_upconverter_test.sv =====
`timescale 1ns / 1ps
module interpolating_multitone_upconverter_test;
	import imu_pkg::*;

	localparam int LUT_BITS = SINE_BITS_DEF;
	localparam int LUT_SIZE = 1 << LUT_BITS;
	localparam int LUT_QTR  = LUT_SIZE / 4;
	localparam int SETTLE   = 120;

	logic                  clk;
	logic                  arst_n;
	logic                  push;
	logic                  full;
	in_item_t              sample;
	logic                  empty;
	logic                  pop;
	out_item_t             result;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// Mixer state and register copies
	int          sine_lut [LUT_SIZE];
	logic [6:0]  ratio_reg;
	logic [1:0]  tones_reg;
	logic [31:0] step_reg [2];
	logic [31:0] offset_reg [2];
	logic [31:0] tone_phase [2];
	longint      prev_i;
	longint      prev_q;
	bit          have_prev;

	in_item_t    baseband_queue [$];
	out_item_t   rf_expected [$];
	bit          in_taken;
	bit          steady;
	int          errors;
	int          samples_in;
	int          rf_checked;
	int          intervals;

	interpolating_multitone_upconverter u_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .sample(sample),
		.empty(empty), .pop(pop), .result(result), .cfg_we(cfg_we),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Quarter-wave sine in Q15 by truncated Taylor series
	function automatic int quarter_wave(int k);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint          acc;
		longint          v;
		x    = (longint'(k) * 64'd1686629713) >> (LUT_BITS - 2);
		x2   = (x * x) >> 30;
		term = x;
		acc  = longint'(x);
		for (int n = 1; n <= 13; n += 2) begin
			term = ((term * x2) >> 30) / longint'((n + 1) * (n + 2));
			if (((n + 1) / 2) % 2 == 1) begin
				acc = acc - longint'(term);
			end else begin
				acc = acc + longint'(term);
			end
		end
		if (acc < 0) begin
			acc = 0;
		end
		v = (acc + 16384) / 32768;
		if (v > 32767) begin
			v = 32767;
		end
		return int'(v);
	endfunction

	function automatic logic signed [15:0] clamp16(longint v);
		if (v > 32767) begin
			return 16'sh7fff;
		end
		if (v < -32768) begin
			return 16'sh8000;
		end
		return v[15:0];
	endfunction

	// Expand one baseband sample into its mixed RF samples
	task automatic predict_interval(in_item_t it);
		longint      cur_i;
		longint      cur_q;
		longint      inc_i;
		longint      inc_q;
		longint      acc_i;
		longint      acc_q;
		longint      si;
		longint      sq;
		longint      s;
		longint      c;
		int          r;
		int          nt;
		int          idx;
		logic [31:0] p;
		out_item_t   o;
		cur_i = longint'(it.sample_i);
		cur_q = longint'(it.sample_q);
		if (!have_prev) begin
			prev_i    = cur_i;
			prev_q    = cur_q;
			have_prev = 1'b1;
			return;
		end
		r  = (ratio_reg == 0) ? 1 : (ratio_reg > MAX_RATIO_DEF) ? MAX_RATIO_DEF : int'(ratio_reg);
		nt = (tones_reg > NUM_TONES_DEF) ? NUM_TONES_DEF : int'(tones_reg);
		inc_i = ((cur_i - prev_i) * 65536) / longint'(r);
		inc_q = ((cur_q - prev_q) * 65536) / longint'(r);
		acc_i = prev_i * 65536;
		acc_q = prev_q * 65536;
		for (int k = 0; k < r; k++) begin
			si = 0;
			sq = 0;
			for (int t = 0; t < nt; t++) begin
				p   = tone_phase[t] + offset_reg[t];
				idx = int'(p >> (32 - LUT_BITS));
				s   = sine_lut[idx];
				c   = sine_lut[(idx + LUT_QTR) % LUT_SIZE];
				si += acc_i * c - acc_q * s;
				sq += acc_i * s + acc_q * c;
			end
			for (int t = 0; t < NUM_TONES_DEF; t++) begin
				tone_phase[t] = tone_phase[t] + step_reg[t];
			end
			o.out_i = clamp16((si + (longint'(1) << 30)) >>> 31);
			o.out_q = clamp16((sq + (longint'(1) << 30)) >>> 31);
			o.last  = (k == r - 1);
			rf_expected.insert(rf_expected.size(), o);
			acc_i += inc_i;
			acc_q += inc_q;
		end
		prev_i = cur_i;
		prev_q = cur_q;
		intervals++;
	endtask

	// Capture input transactions and check result transactions
	always @(posedge clk) begin
		in_taken <= arst_n && push && !full;
		if (arst_n && push && !full) begin
			predict_interval(sample);
			samples_in++;
		end
		if (arst_n && pop && !empty) begin
			if (rf_expected.size() == 0) begin
				$error("unexpected RF sample out_i=%0d out_q=%0d", result.out_i, result.out_q);
				errors++;
			end else begin
				if (result.out_i !== rf_expected[0].out_i) begin
					$error("out_i expected %0d actual %0d", rf_expected[0].out_i, result.out_i);
					errors++;
				end
				if (result.out_q !== rf_expected[0].out_q) begin
					$error("out_q expected %0d actual %0d", rf_expected[0].out_q, result.out_q);
					errors++;
				end
				if (result.last !== rf_expected[0].last) begin
					$error("last expected %0d actual %0d", rf_expected[0].last, result.last);
					errors++;
				end
				void'(rf_expected.pop_front());
				rf_checked++;
			end
		end
	end

	// Drive baseband samples and result pops on the falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_taken) begin
				void'(baseband_queue.pop_front());
			end
			push <= (baseband_queue.size() > 0) && (steady || $urandom_range(99) >= 18);
			if (baseband_queue.size() > 0) begin
				sample <= baseband_queue[0];
			end
			pop <= steady || ($urandom_range(99) >= 18);
		end
	end

	task automatic write_reg(cfg_reg_t r, logic [31:0] v);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= r;
		cfg_data  <= v;
		case (r)
			REG_UPSAMPLE_RATIO: ratio_reg = v[6:0];
			REG_TONE_COUNT:     tones_reg = v[1:0];
			REG_PHASE_STEP_A:   step_reg[0] = v;
			REG_PHASE_STEP_B:   step_reg[1] = v;
			REG_PHASE_OFFSET_A: offset_reg[0] = v;
			REG_PHASE_OFFSET_B: offset_reg[1] = v;
			default: ;
		endcase
	endtask

	task automatic set_all(logic [6:0] r, logic [1:0] n, logic [31:0] sa, logic [31:0] sb,
			logic [31:0] oa, logic [31:0] ob);
		write_reg(REG_UPSAMPLE_RATIO, 32'(r));
		write_reg(REG_TONE_COUNT, 32'(n));
		write_reg(REG_PHASE_STEP_A, sa);
		write_reg(REG_PHASE_STEP_B, sb);
		write_reg(REG_PHASE_OFFSET_A, oa);
		write_reg(REG_PHASE_OFFSET_B, ob);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic add_sample(logic [15:0] i, logic [15:0] q);
		in_item_t it;
		it.sample_i = i;
		it.sample_q = q;
		baseband_queue.insert(baseband_queue.size(), it);
	endtask

	function automatic logic [15:0] rand_component();
		if ($urandom_range(9) == 0) begin
			return $urandom_range(1) ? 16'h7fff : 16'h8000;
		end
		return 16'($urandom);
	endfunction

	// Hold until every sample is taken and every RF sample checked, then settle
	task automatic drain();
		while (baseband_queue.size() > 0 || rf_expected.size() > 0) begin
			@(posedge clk);
		end
		repeat (SETTLE) @(posedge clk);
	endtask

	initial begin
		logic [6:0] r;
		for (int m = 0; m < LUT_SIZE; m++) begin
			case (m / LUT_QTR)
				0: sine_lut[m] = quarter_wave(m % LUT_QTR);
				1: sine_lut[m] = quarter_wave(LUT_QTR - m % LUT_QTR);
				2: sine_lut[m] = -quarter_wave(m % LUT_QTR);
				default: sine_lut[m] = -quarter_wave(LUT_QTR - m % LUT_QTR);
			endcase
		end
		ratio_reg = 7'd1;
		tones_reg = 2'd1;
		step_reg = '{0, 0};
		offset_reg = '{0, 0};
		tone_phase = '{0, 0};
		have_prev = 1'b0;
		prev_i = 0;
		prev_q = 0;
		arst_n = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		sample = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		steady = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset defaults: first sample only primes, then full-scale swings
		add_sample(16'h0000, 16'h0000);
		add_sample(16'h7fff, 16'h7fff);
		add_sample(16'h8000, 16'h8000);
		add_sample(16'h7fff, 16'h8000);
		add_sample(16'h8000, 16'h7fff);
		add_sample(16'h0000, 16'h0000);
		drain();

		// Largest ratio, both tones, extreme steps and offsets
		set_all(7'd64, 2'd2, 32'hffffffff, 32'h40000000, 32'hffffffff, 32'h80000000);
		add_sample(16'h7fff, 16'h8000);
		add_sample(16'h8000, 16'h7fff);
		add_sample(16'h7fff, 16'h7fff);
		add_sample(16'h8000, 16'h8000);
		drain();

		// Zero ratio acts as one; zero tones mix nothing
		set_all(7'd0, 2'd0, 32'h12345678, 32'h9abcdef0, 32'h0, 32'h0);
		add_sample(16'h7fff, 16'h7fff);
		add_sample(16'h8000, 16'h0001);
		add_sample(16'h1234, 16'hfedc);
		drain();

		// Ratio above the maximum and tone count above two
		set_all(7'd127, 2'd3, 32'h01000000, 32'hfe000000, 32'h3fffffff, 32'hc0000000);
		add_sample(16'h8000, 16'h8000);
		add_sample(16'h7fff, 16'h7fff);
		add_sample(16'h0000, 16'hffff);
		drain();

		// Random settings, mostly small ratios
		for (int ph = 0; ph < 8; ph++) begin
			case ($urandom_range(9))
				0: r = 7'd64;
				1: r = 7'($urandom_range(65, 127));
				2: r = 7'd0;
				default: r = 7'($urandom_range(1, 16));
			endcase
			set_all(r, 2'($urandom_range(3)), $urandom, $urandom, $urandom, $urandom);
			steady = (ph == 5);
			for (int n = 0; n < 39; n++) begin
				add_sample(rand_component(), rand_component());
			end
			drain();
		end
		steady = 1'b0;

		$display("%0d baseband samples, %0d intervals, %0d RF samples checked",
			samples_in, intervals, rf_checked);
		$display("ratios from zero to beyond the maximum, tone counts zero to three");
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	initial begin
		#5000000;
		$display("status: fail");
		$finish;
	end

endmodule

// ===== interpolating_multitone_upconverter.f =====
+incdir+hw/rtl
hw/rtl/imu_pkg.sv
hw/rtl/imu_fifo.sv
hw/rtl/imu_front.sv
hw/rtl/imu_back.sv
hw/rtl/interpolating_multitone_upconverter.sv
bench/interpolating_multitone_upconverter_test.sv
